// ===== rtl/mcct_pkg.sv =====
// Package: shared types, constants and helpers of the countdown timer bank.
`timescale 1ns / 1ps
`default_nettype none
package mcct_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int COUNT_WIDTH = 24;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IDX_W-1:0]       idx_t;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_START  = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_RESET  = 3'd4,
    CMD_DELETE = 3'd5,
    CMD_TICK   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    EV_DONE    = 2'd0,
    EV_IGNORED = 2'd1,
    EV_EXPIRED = 2'd2,
    EV_FULL    = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    ST_STOPPED  = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_PAUSED   = 2'd2,
    ST_FINISHED = 2'd3
  } st_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIRECT,
    S_READ,
    S_CMD,
    S_TICK_RD,
    S_TICK_EX,
    S_FLUSH
  } seq_state_e;

  // One slot as stored in the slot memory.
  typedef struct packed {
    count_t reload;
    count_t left;
    logic   rep;
    st_e    st;
  } rec_t;

  typedef struct packed {
    logic [3:0]  slot;
    ev_e         ev;
    st_e         st;
    logic [23:0] rem;
    logic        last;
  } res_t;

  // Valid-bit updates from the sequencer.
  typedef struct packed {
    logic set;
    logic clr;
    idx_t idx;
  } vctl_t;

  // Valid bits and first free slot back to the sequencer.
  typedef struct packed {
    logic [NUM_TIMERS-1:0] bits;
    logic                  free;
    idx_t                  free_idx;
  } vsts_t;

  function automatic count_t sat_len(input logic [23:0] len);
    logic [32:0] w;
    w = 33'(len);
    if (w > COUNT_MAX) begin
      w = COUNT_MAX;
    end
    return w[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [23:0] to_rem(input count_t c);
    logic [32:0] w;
    w = 33'(c);
    return w[23:0];
  endfunction

  function automatic idx_t slot_to_idx(input logic [3:0] s);
    logic [7:0] w;
    w = 8'(s);
    return w[IDX_W-1:0];
  endfunction

  function automatic logic [3:0] idx_to_slot(input idx_t i);
    logic [7:0] w;
    w = 8'(i);
    return w[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mcct_if.sv =====
// Interfaces: request and result channels of the countdown timer bank.
`timescale 1ns / 1ps
`default_nettype none
interface mcct_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  slot;
  logic [23:0] length_seconds;
  logic        auto_reload;

  modport source (output valid, command, slot, length_seconds, auto_reload, input ready);
  modport sink   (input valid, command, slot, length_seconds, auto_reload, output ready);
endinterface

interface mcct_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  result_slot;
  logic [1:0]  event_kind;
  logic [1:0]  timer_state;
  logic [23:0] remaining_seconds;
  logic        last_result;

  modport source (output valid, result_slot, event_kind, timer_state, remaining_seconds,
                  last_result, input ready);
  modport sink   (input valid, result_slot, event_kind, timer_state, remaining_seconds,
                  last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/mcct_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mcct_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mcct_valid.sv =====
// Slot valid bits and first-free-slot search.
`timescale 1ns / 1ps
`default_nettype none
module mcct_valid (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mcct_pkg::vctl_t vctl_i,
  output mcct_pkg::vsts_t      vsts_o
);
  import mcct_pkg::*;

  logic [NUM_TIMERS-1:0] valid_q, valid_d;

  always_comb begin
    valid_d = valid_q;
    if (vctl_i.set) begin
      valid_d[vctl_i.idx] = 1'b1;
    end
    if (vctl_i.clr) begin
      valid_d[vctl_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Lowest free slot wins: scan downward so the last hit is the lowest index.
  always_comb begin
    vsts_o.bits     = valid_q;
    vsts_o.free     = 1'b0;
    vsts_o.free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        vsts_o.free     = 1'b1;
        vsts_o.free_idx = idx_t'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mcct_seq.sv =====
// Sequencer: command decode, slot read-modify-write, tick sweep and result register.
`timescale 1ns / 1ps
`default_nettype none
module mcct_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  mcct_req_if.sink             req_i,
  mcct_rsp_if.source           rsp_o,
  input  wire mcct_pkg::vsts_t vsts_i,
  output mcct_pkg::vctl_t      vctl_o,
  output logic                 ram_we_o,
  output mcct_pkg::idx_t       ram_waddr_o,
  output mcct_pkg::rec_t       ram_wdata_o,
  output logic                 ram_re_o,
  output mcct_pkg::idx_t       ram_raddr_o,
  input  wire mcct_pkg::rec_t  ram_rdata_i
);
  import mcct_pkg::*;

  seq_state_e state_q, state_d;

  // captured request
  logic [2:0]  cmd_q;
  logic [3:0]  slot_q;
  logic [23:0] len_q;
  logic        rep_q;

  idx_t             idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  res_t             held_q, held_d;
  logic             held_vld_q, held_vld_d;
  res_t             out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic   out_free;
  logic   accept;
  logic   slot_ok;
  idx_t   cur_idx;
  logic   last_idx;

  // tick evaluation of the slot under the sweep
  logic   t_hit, t_exp, t_report, t_stall;
  rec_t   t_new;
  res_t   t_res;

  // command evaluation of the addressed slot
  logic   c_ok, c_we, c_del;
  rec_t   c_new;
  res_t   c_res;

  // direct results (add, empty slot)
  res_t   d_res;
  count_t a_len;

  assign out_free = !out_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign accept   = req_i.valid && req_i.ready;
  assign slot_ok  = (32'(req_i.slot) < NUM_TIMERS) && vsts_i.bits[slot_to_idx(req_i.slot)];
  assign cur_idx  = slot_to_idx(slot_q);
  assign last_idx = (idx_q == idx_t'(NUM_TIMERS - 1));
  assign a_len    = sat_len(len_q);

  always_comb begin
    t_new    = ram_rdata_i;
    t_hit    = vsts_i.bits[idx_q] && (ram_rdata_i.st == ST_RUNNING) && (ram_rdata_i.left != '0);
    t_new.left = ram_rdata_i.left - count_t'(1);
    t_exp    = t_hit && (t_new.left == '0);
    if (t_exp) begin
      if (ram_rdata_i.rep) begin
        t_new.left = ram_rdata_i.reload;
        t_new.st   = ST_RUNNING;
      end else begin
        t_new.st   = ST_FINISHED;
      end
    end
    t_report = t_exp && (cnt_q < CNT_W'(MAX_RESULTS));
    t_stall  = t_report && held_vld_q && !out_free;
    t_res.slot = idx_to_slot(idx_q);
    t_res.ev   = EV_EXPIRED;
    t_res.st   = t_new.st;
    t_res.rem  = to_rem(t_new.left);
    t_res.last = 1'b0;
  end

  always_comb begin
    c_new = ram_rdata_i;
    c_ok  = 1'b0;
    c_we  = 1'b0;
    c_del = 1'b0;
    case (cmd_q)
      CMD_START: begin
        if (ram_rdata_i.st == ST_STOPPED || ram_rdata_i.st == ST_PAUSED) begin
          c_new.st = ST_RUNNING;
          c_ok     = 1'b1;
          c_we     = 1'b1;
        end
      end
      CMD_PAUSE: begin
        if (ram_rdata_i.st == ST_RUNNING) begin
          c_new.st = ST_PAUSED;
          c_ok     = 1'b1;
          c_we     = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (ram_rdata_i.st == ST_PAUSED) begin
          c_new.st = ST_RUNNING;
          c_ok     = 1'b1;
          c_we     = 1'b1;
        end
      end
      CMD_RESET: begin
        c_new.st   = ST_STOPPED;
        c_new.left = ram_rdata_i.reload;
        c_ok       = 1'b1;
        c_we       = 1'b1;
      end
      CMD_DELETE: begin
        c_ok  = 1'b1;
        c_del = 1'b1;
      end
      default: begin
      end
    endcase
    c_res.slot = slot_q;
    c_res.ev   = c_ok ? EV_DONE : EV_IGNORED;
    c_res.st   = c_del ? ST_STOPPED : c_new.st;
    c_res.rem  = c_del ? 24'd0 : to_rem(c_new.left);
    c_res.last = 1'b1;
  end

  always_comb begin
    d_res.last = 1'b1;
    d_res.st   = ST_STOPPED;
    d_res.rem  = '0;
    d_res.slot = '0;
    d_res.ev   = EV_IGNORED;
    if (cmd_q == CMD_ADD) begin
      if (len_q == '0) begin
        d_res.ev = EV_IGNORED;
      end else if (!vsts_i.free) begin
        d_res.ev = EV_FULL;
      end else begin
        d_res.ev   = EV_DONE;
        d_res.slot = idx_to_slot(vsts_i.free_idx);
        d_res.rem  = to_rem(a_len);
      end
    end else begin
      d_res.slot = slot_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.command == CMD_TICK) begin
            state_d = S_TICK_RD;
          end else if (req_i.command == CMD_ADD) begin
            state_d = S_DIRECT;
          end else if (slot_ok) begin
            state_d = S_READ;
          end else begin
            state_d = S_DIRECT;
          end
        end
      end
      S_DIRECT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_READ:    state_d = S_CMD;
      S_CMD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_TICK_RD: state_d = S_TICK_EX;
      S_TICK_EX: begin
        if (!t_stall) begin
          state_d = last_idx ? S_FLUSH : S_TICK_RD;
        end
      end
      S_FLUSH: begin
        if (!held_vld_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ram_re_o    = 1'b0;
    ram_raddr_o = cur_idx;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_idx;
    ram_wdata_o = c_new;
    vctl_o      = '0;
    vctl_o.idx  = cur_idx;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    held_d      = held_q;
    held_vld_d  = held_vld_q;
    out_d       = out_q;
    out_vld_d   = rsp_o.ready ? 1'b0 : out_vld_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d      = '0;
          cnt_d      = '0;
          held_vld_d = 1'b0;
        end
      end
      S_DIRECT: begin
        if (out_free) begin
          out_d     = d_res;
          out_vld_d = 1'b1;
          if (cmd_q == CMD_ADD && len_q != '0 && vsts_i.free) begin
            ram_we_o           = 1'b1;
            ram_waddr_o        = vsts_i.free_idx;
            ram_wdata_o.reload = a_len;
            ram_wdata_o.left   = a_len;
            ram_wdata_o.rep    = rep_q;
            ram_wdata_o.st     = ST_STOPPED;
            vctl_o.set         = 1'b1;
            vctl_o.idx         = vsts_i.free_idx;
          end
        end
      end
      S_READ: begin
        ram_re_o = 1'b1;
      end
      S_CMD: begin
        if (out_free) begin
          out_d      = c_res;
          out_vld_d  = 1'b1;
          ram_we_o   = c_we;
          vctl_o.clr = c_del;
        end
      end
      S_TICK_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = idx_q;
      end
      S_TICK_EX: begin
        if (!t_stall) begin
          ram_we_o    = t_hit;
          ram_waddr_o = idx_q;
          ram_wdata_o = t_new;
          if (t_report) begin
            // push the earlier expiry out, keep this one back until the next expiry or the end of the sweep
            if (held_vld_q) begin
              out_d     = held_q;
              out_vld_d = 1'b1;
            end
            held_d     = t_res;
            held_vld_d = 1'b1;
            cnt_d      = cnt_q + CNT_W'(1);
          end
          if (!last_idx) begin
            idx_d = idx_q + idx_t'(1);
          end
        end
      end
      S_FLUSH: begin
        if (held_vld_q && out_free) begin
          out_d      = held_q;
          out_d.last = 1'b1;
          out_vld_d  = 1'b1;
          held_vld_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      out_vld_q  <= 1'b0;
      held_vld_q <= 1'b0;
      idx_q      <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      out_vld_q  <= out_vld_d;
      held_vld_q <= held_vld_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    held_q <= held_d;
    if (accept) begin
      cmd_q  <= req_i.command;
      slot_q <= req_i.slot;
      len_q  <= req_i.length_seconds;
      rep_q  <= req_i.auto_reload;
    end
  end

  assign rsp_o.valid             = out_vld_q;
  assign rsp_o.result_slot       = out_q.slot;
  assign rsp_o.event_kind        = out_q.ev;
  assign rsp_o.timer_state       = out_q.st;
  assign rsp_o.remaining_seconds = out_q.rem;
  assign rsp_o.last_result       = out_q.last;

endmodule
`default_nettype wire

// ===== rtl/multi_channel_countdown_timer.sv =====
// Top level: bank of countdown timers with auto-reload, slot state in one RAM.
//
//   channel   dir  handshake        contents
//   req_i     in   valid / ready    command, slot, length_seconds, auto_reload
//   rsp_o     out  valid / ready    result_slot, event_kind, timer_state,
//                                   remaining_seconds, last_result
//
// One request at a time. Add, or a command on an empty slot, is answered from
// S_DIRECT; other commands read the slot RAM, then update and write back.
// A tick sweeps every slot (read, then update), then flushes the held result;
// the sweep stalls on an expiry while an earlier one is held and the output is full.
// Reset clears the valid bits and the sequencer state; the slot RAM needs no clearing pass.
// The request side is ready again while the last result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module multi_channel_countdown_timer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mcct_req_if.sink   req_i,
  mcct_rsp_if.source rsp_o
);
  import mcct_pkg::*;

  vctl_t vctl;
  vsts_t vsts;
  logic  ram_we;
  logic  ram_re;
  idx_t  ram_waddr;
  idx_t  ram_raddr;
  rec_t  ram_wdata;
  rec_t  ram_rdata;

  mcct_valid u_valid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vctl_i (vctl),
    .vsts_o (vsts)
  );

  mcct_ram #(
    .WIDTH  ($bits(rec_t)),
    .DEPTH  (NUM_TIMERS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mcct_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .vsts_i      (vsts),
    .vctl_o      (vctl),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule
`default_nettype wire

// ===== tb/tb_multi_channel_countdown_timer.sv =====
// Testbench: drives timer commands and ticks, predicts every result and checks it.
`timescale 1ns / 1ps
module tb_multi_channel_countdown_timer;
  import mcct_pkg::*;

  // Command code outside the defined set; the block answers it as ignored.
  localparam logic [2:0] CMD_UNDEFINED = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [23:0] len;
    logic        rep;
    logic        typed;
    res_t        want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mcct_req_if req_bus ();
  mcct_rsp_if rsp_bus ();

  multi_channel_countdown_timer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the slot bank.
  bit     slot_used   [NUM_TIMERS];
  count_t reload_len  [NUM_TIMERS];
  count_t secs_left   [NUM_TIMERS];
  logic   reload_flag [NUM_TIMERS];
  st_e    run_st      [NUM_TIMERS];

  res_t awaited_results[$];
  int   mismatches   = 0;
  int   items_sent   = 0;
  bit   no_idle      = 1'b0;
  int   stall_left   = 0;

  function automatic void timer_bank_step(input logic [2:0] cmd, input logic [3:0] slot,
                                          input logic [23:0] len, input logic rep,
                                          ref res_t outs[$]);
    res_t r;
    int   free_idx;
    bit   ok;
    outs.delete();
    if (cmd == CMD_TICK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (slot_used[i] && run_st[i] == ST_RUNNING && secs_left[i] != '0) begin
          secs_left[i] = secs_left[i] - 1'b1;
          if (secs_left[i] == '0) begin
            if (reload_flag[i]) begin
              secs_left[i] = reload_len[i];
            end else begin
              run_st[i] = ST_FINISHED;
            end
            if (outs.size() < MAX_RESULTS) begin
              r = '{4'(i), EV_EXPIRED, run_st[i], secs_left[i], 1'b0};
              outs.push_back(r);
            end
          end
        end
      end
      if (outs.size() > 0) begin
        outs[outs.size()-1].last = 1'b1;
      end
      return;
    end
    if (cmd == CMD_ADD) begin
      free_idx = -1;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (!slot_used[i] && free_idx < 0) begin
          free_idx = i;
        end
      end
      if (len == '0) begin
        r = '{4'd0, EV_IGNORED, ST_STOPPED, 24'd0, 1'b1};
      end else if (free_idx < 0) begin
        r = '{4'd0, EV_FULL, ST_STOPPED, 24'd0, 1'b1};
      end else begin
        slot_used[free_idx]   = 1'b1;
        reload_len[free_idx]  = len;
        secs_left[free_idx]   = len;
        reload_flag[free_idx] = rep;
        run_st[free_idx]      = ST_STOPPED;
        r = '{4'(free_idx), EV_DONE, ST_STOPPED, len, 1'b1};
      end
      outs.push_back(r);
      return;
    end
    if (!slot_used[slot]) begin
      r = '{slot, EV_IGNORED, ST_STOPPED, 24'd0, 1'b1};
      outs.push_back(r);
      return;
    end
    ok = 1'b0;
    case (cmd)
      CMD_START: begin
        if (run_st[slot] == ST_STOPPED || run_st[slot] == ST_PAUSED) begin
          run_st[slot] = ST_RUNNING;
          ok = 1'b1;
        end
      end
      CMD_PAUSE: begin
        if (run_st[slot] == ST_RUNNING) begin
          run_st[slot] = ST_PAUSED;
          ok = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (run_st[slot] == ST_PAUSED) begin
          run_st[slot] = ST_RUNNING;
          ok = 1'b1;
        end
      end
      CMD_RESET: begin
        run_st[slot]    = ST_STOPPED;
        secs_left[slot] = reload_len[slot];
        ok = 1'b1;
      end
      CMD_DELETE: begin
        slot_used[slot] = 1'b0;
        r = '{slot, EV_DONE, ST_STOPPED, 24'd0, 1'b1};
        outs.push_back(r);
        return;
      end
      default: begin
      end
    endcase
    r = '{slot, ok ? EV_DONE : EV_IGNORED, run_st[slot], secs_left[slot], 1'b1};
    outs.push_back(r);
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [3:0] pick_slot();
    int live[$];
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (slot_used[i]) begin
        live.push_back(i);
      end
    end
    if (live.size() == 0 || $urandom_range(0, 99) < 15) begin
      return 4'($urandom_range(0, 15));
    end
    return 4'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  function automatic logic [23:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      return 24'd0;
    end else if (r < 15) begin
      return 24'($urandom);
    end
    return 24'($urandom_range(1, 6));
  endfunction

  // Call at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [2:0] cmd, input logic [3:0] slot,
                              input logic [23:0] len, input logic rep,
                              input logic typed, input res_t want);
    res_t outs[$];
    int   gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.command        = cmd;
    req_bus.slot           = slot;
    req_bus.length_seconds = len;
    req_bus.auto_reload    = rep;
    req_bus.valid          = 1'b1;
    do @(posedge clk_i); while (!req_bus.ready);
    timer_bank_step(cmd, slot, len, rep, outs);
    if (typed) begin
      outs.delete();
      outs.push_back(want);
    end
    foreach (outs[k]) begin
      awaited_results.push_back(outs[k]);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // Empty the bank, fill it, overfill it, then expire all sixteen on one tick.
  task automatic run_burst();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (slot_used[i]) begin
        send_request(CMD_DELETE, 4'(i), 24'($urandom), 1'($urandom), 1'b0, '0);
      end
    end
    repeat (NUM_TIMERS) begin
      send_request(CMD_ADD, 4'($urandom), 24'd1, 1'($urandom), 1'b0, '0);
    end
    send_request(CMD_ADD, 4'($urandom), 24'd3, 1'b0, 1'b0, '0);
    for (int i = 0; i < NUM_TIMERS; i++) begin
      send_request(CMD_START, 4'(i), 24'($urandom), 1'($urandom), 1'b0, '0);
    end
    send_request(CMD_TICK, 4'($urandom), 24'($urandom), 1'($urandom), 1'b0, '0);
    send_request(CMD_TICK, 4'($urandom), 24'($urandom), 1'($urandom), 1'b0, '0);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        rsp_bus.ready = 1'b0;
        stall_left--;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        rsp_bus.ready = 1'b1;
      end else begin
        rsp_bus.ready = 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got.slot = rsp_bus.result_slot;
      got.ev   = ev_e'(rsp_bus.event_kind);
      got.st   = st_e'(rsp_bus.timer_state);
      got.rem  = rsp_bus.remaining_seconds;
      got.last = rsp_bus.last_result;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result slot %0d ev %0d st %0d rem %0d last %0d",
                 $time, got.slot, got.ev, got.st, got.rem, got.last);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected slot %0d ev %0d st %0d rem %0d last %0d",
                   $time, want.slot, want.ev, want.st, want.rem, want.last);
          $display("%0t:          actual   slot %0d ev %0d st %0d rem %0d last %0d",
                   $time, got.slot, got.ev, got.st, got.rem, got.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    script_row_t script[$];
    script_row_t row;
    int          r;
    int          target;
    int          burst_at;
    int          guard;

    rst_ni                 = 1'b0;
    req_bus.valid          = 1'b0;
    req_bus.command        = CMD_TICK;
    req_bus.slot           = '0;
    req_bus.length_seconds = '0;
    req_bus.auto_reload    = 1'b0;
    rsp_bus.ready          = 1'b0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      slot_used[i] = 1'b0;
    end

    script.push_back('{CMD_TICK, 4'd0, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_START, 4'd3, 24'd0, 1'b0, 1'b1,
                       '{4'd3, EV_IGNORED, ST_STOPPED, 24'd0, 1'b1}});
    script.push_back('{CMD_ADD, 4'd9, 24'd0, 1'b1, 1'b1,
                       '{4'd0, EV_IGNORED, ST_STOPPED, 24'd0, 1'b1}});
    script.push_back('{CMD_ADD, 4'd0, 24'hFFFFFF, 1'b0, 1'b1,
                       '{4'd0, EV_DONE, ST_STOPPED, 24'hFFFFFF, 1'b1}});
    script.push_back('{CMD_ADD, 4'd0, 24'd1, 1'b1, 1'b1,
                       '{4'd1, EV_DONE, ST_STOPPED, 24'd1, 1'b1}});
    script.push_back('{CMD_ADD, 4'd0, 24'd1, 1'b0, 1'b1,
                       '{4'd2, EV_DONE, ST_STOPPED, 24'd1, 1'b1}});
    script.push_back('{CMD_PAUSE, 4'd1, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_RESUME, 4'd1, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_START, 4'd1, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_START, 4'd2, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_START, 4'd0, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_START, 4'd1, 24'd0, 1'b0, 1'b0, '0});
    // Slot 1 reloads and slot 2 finishes on the same tick.
    script.push_back('{CMD_TICK, 4'd0, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_TICK, 4'd0, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_START, 4'd2, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_PAUSE, 4'd0, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_RESUME, 4'd0, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_RESET, 4'd0, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_UNDEFINED, 4'd0, 24'd0, 1'b0, 1'b0, '0});
    script.push_back('{CMD_UNDEFINED, 4'd15, 24'hFFFFFF, 1'b1, 1'b1,
                       '{4'd15, EV_IGNORED, ST_STOPPED, 24'd0, 1'b1}});
    script.push_back('{CMD_DELETE, 4'd2, 24'd0, 1'b0, 1'b1,
                       '{4'd2, EV_DONE, ST_STOPPED, 24'd0, 1'b1}});
    script.push_back('{CMD_DELETE, 4'd2, 24'd0, 1'b0, 1'b1,
                       '{4'd2, EV_IGNORED, ST_STOPPED, 24'd0, 1'b1}});
    script.push_back('{CMD_ADD, 4'd0, 24'h5A5A5, 1'b1, 1'b0, '0});
    script.push_back('{CMD_RESET, 4'd15, 24'd0, 1'b0, 1'b1,
                       '{4'd15, EV_IGNORED, ST_STOPPED, 24'd0, 1'b1}});

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[k]) begin
      row = script[k];
      send_request(row.cmd, row.slot, row.len, row.rep, row.typed, row.want);
    end

    target   = 220;
    burst_at = items_sent;
    while (items_sent < target) begin
      if ($urandom_range(0, 29) == 0) begin
        no_idle = !no_idle;
      end
      if (items_sent >= burst_at) begin
        run_burst();
        burst_at = items_sent + 110;
      end
      r = $urandom_range(0, 99);
      if (r < 18) begin
        send_request(CMD_ADD, 4'($urandom), pick_length(), 1'($urandom), 1'b0, '0);
      end else if (r < 50) begin
        send_request(CMD_TICK, 4'($urandom), 24'($urandom), 1'($urandom), 1'b0, '0);
      end else if (r < 62) begin
        send_request(CMD_START, pick_slot(), 24'($urandom), 1'($urandom), 1'b0, '0);
      end else if (r < 70) begin
        send_request(CMD_PAUSE, pick_slot(), 24'($urandom), 1'($urandom), 1'b0, '0);
      end else if (r < 77) begin
        send_request(CMD_RESUME, pick_slot(), 24'($urandom), 1'($urandom), 1'b0, '0);
      end else if (r < 83) begin
        send_request(CMD_RESET, pick_slot(), 24'($urandom), 1'($urandom), 1'b0, '0);
      end else if (r < 91) begin
        send_request(CMD_DELETE, pick_slot(), 24'($urandom), 1'($urandom), 1'b0, '0);
      end else if (r < 94) begin
        send_request(CMD_UNDEFINED, pick_slot(), 24'($urandom), 1'($urandom), 1'b0, '0);
      end else begin
        send_request(3'($urandom), 4'($urandom), 24'($urandom), 1'($urandom), 1'b0, '0);
      end
    end
    req_bus.valid = 1'b0;
    no_idle       = 1'b0;

    guard = 0;
    while (awaited_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);

    if (awaited_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
    end
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
